@@ rtl/core/bounded_array_list_engine_macros.svh @@
// Assertion macros shared by the array list engine RTL.
`ifndef BOUNDED_ARRAY_LIST_ENGINE_MACROS_SVH
`define BOUNDED_ARRAY_LIST_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
`define BALE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define BALE_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define BALE_ASSERT(lbl, clk, rst, prop, msg)
`define BALE_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`endif
`endif

@@ rtl/core/bale_pkg.sv @@
// Shared constants and types of the array list engine.
`timescale 1ns / 1ps
`default_nettype none
package bale_pkg;

   localparam int BALE_CAPACITY = 64;
   localparam int BALE_KEY_BITS = 32;

   localparam int OPCODE_BITS = 3;
   localparam int POS_BITS    = 7;
   localparam int INDEX_BITS  = 6;
   localparam int SIZE_BITS   = 7;

   typedef enum logic [OPCODE_BITS-1:0] {
      OP_INSERT_AT     = 3'd0,
      OP_SORTED_INSERT = 3'd1,
      OP_DELETE        = 3'd2,
      OP_FIND          = 3'd3,
      OP_BSEARCH       = 3'd4,
      OP_COUNT         = 3'd5,
      OP_CLEAR         = 3'd6
   } opcode_type;

endpackage
`default_nettype wire

@@ rtl/core/bale_chan_if.sv @@
// Request and response channel interfaces of the array list engine.
`timescale 1ns / 1ps
`default_nettype none
interface bale_req_if
   import bale_pkg::*;
#(
   parameter int KEY_BITS = BALE_KEY_BITS
);
   logic                       valid;
   logic                       ready;
   logic [OPCODE_BITS-1:0]     opcode;
   logic [POS_BITS-1:0]        position;
   logic signed [KEY_BITS-1:0] key;

   modport source (output valid, opcode, position, key, input ready);
   modport sink   (input valid, opcode, position, key, output ready);
endinterface

interface bale_rsp_if
   import bale_pkg::*;
;
   logic                  valid;
   logic                  ready;
   logic                  ok;
   logic [INDEX_BITS-1:0] index;
   logic [SIZE_BITS-1:0]  match_count;
   logic [SIZE_BITS-1:0]  list_size;

   modport source (output valid, ok, index, match_count, list_size, input ready);
   modport sink   (input valid, ok, index, match_count, list_size, output ready);
endinterface
`default_nettype wire

@@ rtl/core/bale_ram.sv @@
// Single-port-write, single-port-read key store with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module bale_ram
   import bale_pkg::*;
#(
   parameter int DEPTH = BALE_CAPACITY,
   parameter int WIDTH = BALE_KEY_BITS
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/bounded_array_list_engine.sv @@
// Array list engine top level: ordered key list with insert, delete and search.
//
// req_chan carries opcode, position and key; rsp_chan returns ok, index,
// match_count and list_size, exactly one response item per request item.
// Both channels move an item when valid and ready are high at a clock edge.
// One request item is processed at a time; req_chan.ready is high only while
// the engine waits for work and reset is low. The keys sit in one memory with
// one read and one write per cycle and registered read data.
// Insert at a position, sorted insert, delete, find and count walk the
// memory one entry per cycle; binary search reads a probe, then compares
// it and narrows the range. Clear and rejected items go straight to the
// response.
// A finished response waits in the output register while the receiver
// stalls; the next request is taken meanwhile, and its own response holds
// until the register is free. Reset empties the list and drops any response.
// The key memory needs no clearing after reset.
`timescale 1ns / 1ps
`default_nettype none
`include "bounded_array_list_engine_macros.svh"
module bounded_array_list_engine
   import bale_pkg::*;
#(
   parameter int CAPACITY = BALE_CAPACITY,
   parameter int KEY_BITS = BALE_KEY_BITS
) (
   input wire logic   clock,
   input wire logic   reset,
   bale_req_if.sink   req_chan,
   bale_rsp_if.source rsp_chan
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = (CW > POS_BITS) ? CW : POS_BITS;
   localparam int XW = (AW > INDEX_BITS) ? AW : INDEX_BITS;
   localparam int SW = (CW > SIZE_BITS) ? CW : SIZE_BITS;
   localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_BIN_RD,
      S_BIN_CMP,
      S_RESP
   } state_type;

   state_type                  state_ff, state_in;
   opcode_type                 op_ff, op_in;
   logic signed [KEY_BITS-1:0] key_ff, key_in;
   logic [AW-1:0]              pos_ff, pos_in;
   logic [CW-1:0]              cnt_ff, cnt_in;
   logic [AW-1:0]              ptr_ff, ptr_in;
   logic [CW-1:0]              rem_ff, rem_in;
   logic                       dv_ff, dv_in;
   logic [AW-1:0]              didx_ff, didx_in;
   logic                       found_ff, found_in;
   logic [AW-1:0]              fidx_ff, fidx_in;
   logic [CW-1:0]              mcnt_ff, mcnt_in;
   logic                       ok_ff, ok_in;
   logic [CW-1:0]              lo_ff, lo_in;
   logic [CW-1:0]              hx_ff, hx_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_ok_ff, rsp_ok_in;
   logic [INDEX_BITS-1:0]      rsp_index_ff, rsp_index_in;
   logic [SIZE_BITS-1:0]       rsp_mcnt_ff, rsp_mcnt_in;
   logic [SIZE_BITS-1:0]       rsp_size_ff, rsp_size_in;

   logic                       wr_en;
   logic [AW-1:0]              wr_addr;
   logic signed [KEY_BITS-1:0] wr_data;
   logic                       rd_en;
   logic [AW-1:0]              rd_addr;
   logic signed [KEY_BITS-1:0] rd_data;

   logic                       scan_down;
   logic                       hit;
   logic                       above;
   logic [PW-1:0]              pos_wide;
   logic [PW-1:0]              cnt_wide;
   logic [CW:0]                mid_sum;
   logic [AW-1:0]              mid;
   logic [XW-1:0]              fidx_wide;
   logic [SW-1:0]              mcnt_wide;
   logic [SW-1:0]              size_wide;

   bale_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (KEY_BITS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_chan.ready       = (state_ff == S_IDLE) && !reset;
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.ok          = rsp_ok_ff;
   assign rsp_chan.index       = rsp_index_ff;
   assign rsp_chan.match_count = rsp_mcnt_ff;
   assign rsp_chan.list_size   = rsp_size_ff;

   assign scan_down = (op_ff == OP_INSERT_AT) || (op_ff == OP_SORTED_INSERT);
   assign hit       = dv_ff && (rd_data == key_ff);
   assign above     = rd_data > key_ff;
   assign pos_wide  = PW'(req_chan.position);
   assign cnt_wide  = PW'(cnt_ff);
   assign mid_sum   = (CW+1)'(lo_ff) + (CW+1)'(hx_ff) - (CW+1)'(1);
   assign mid       = AW'(mid_sum >> 1);
   assign fidx_wide = XW'(fidx_ff);
   assign mcnt_wide = SW'(mcnt_ff);
   assign size_wide = SW'(cnt_ff);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      pos_in       = pos_ff;
      cnt_in       = cnt_ff;
      ptr_in       = ptr_ff;
      rem_in       = rem_ff;
      dv_in        = 1'b0;
      didx_in      = didx_ff;
      found_in     = found_ff;
      fidx_in      = fidx_ff;
      mcnt_in      = mcnt_ff;
      ok_in        = ok_ff;
      lo_in        = lo_ff;
      hx_in        = hx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_index_in = rsp_index_ff;
      rsp_mcnt_in  = rsp_mcnt_ff;
      rsp_size_in  = rsp_size_ff;
      wr_en        = 1'b0;
      wr_addr      = pos_ff;
      wr_data      = key_ff;
      rd_en        = 1'b0;
      rd_addr      = ptr_ff;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               op_in    = opcode_type'(req_chan.opcode);
               key_in   = req_chan.key;
               ok_in    = 1'b0;
               fidx_in  = '0;
               mcnt_in  = '0;
               found_in = 1'b0;
               state_in = S_RESP;
               case (opcode_type'(req_chan.opcode))
                  OP_INSERT_AT: begin
                     if (pos_wide <= cnt_wide && cnt_ff < CAP_CNT) begin
                        pos_in   = AW'(req_chan.position);
                        ptr_in   = AW'(cnt_ff - CW'(1));
                        rem_in   = cnt_ff - CW'(req_chan.position);
                        state_in = S_SCAN;
                     end
                  end
                  OP_SORTED_INSERT: begin
                     if (cnt_ff < CAP_CNT) begin
                        pos_in   = '0;
                        ptr_in   = AW'(cnt_ff - CW'(1));
                        rem_in   = cnt_ff;
                        state_in = S_SCAN;
                     end
                  end
                  OP_DELETE, OP_FIND, OP_COUNT: begin
                     ptr_in   = '0;
                     rem_in   = cnt_ff;
                     state_in = S_SCAN;
                  end
                  OP_BSEARCH: begin
                     lo_in    = '0;
                     hx_in    = cnt_ff;
                     state_in = S_BIN_RD;
                  end
                  OP_CLEAR: begin
                     cnt_in = '0;
                     ok_in  = 1'b1;
                  end
                  default: begin
                     ok_in = 1'b0;
                  end
               endcase
            end
         end

         S_SCAN: begin
            if (rem_ff != '0) begin
               rd_en   = 1'b1;
               dv_in   = 1'b1;
               didx_in = ptr_ff;
               rem_in  = rem_ff - CW'(1);
               ptr_in  = scan_down ? ptr_ff - AW'(1) : ptr_ff + AW'(1);
            end
            if (dv_ff) begin
               case (op_ff)
                  OP_INSERT_AT: begin
                     wr_en   = 1'b1;
                     wr_addr = didx_ff + AW'(1);
                     wr_data = rd_data;
                  end
                  OP_SORTED_INSERT: begin
                     wr_en   = 1'b1;
                     wr_addr = didx_ff + AW'(1);
                     if (above) begin
                        wr_data = rd_data;
                     end else begin
                        wr_data  = key_ff;
                        ok_in    = 1'b1;
                        fidx_in  = didx_ff + AW'(1);
                        cnt_in   = cnt_ff + CW'(1);
                        state_in = S_RESP;
                     end
                  end
                  OP_DELETE: begin
                     if (found_ff) begin
                        wr_en   = 1'b1;
                        wr_addr = didx_ff - AW'(1);
                        wr_data = rd_data;
                     end else if (hit) begin
                        found_in = 1'b1;
                        fidx_in  = didx_ff;
                     end
                  end
                  OP_FIND: begin
                     if (hit) begin
                        ok_in    = 1'b1;
                        fidx_in  = didx_ff;
                        state_in = S_RESP;
                     end
                  end
                  OP_COUNT: begin
                     if (hit) begin
                        mcnt_in = mcnt_ff + CW'(1);
                     end
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end else if (rem_ff == '0) begin
               state_in = S_RESP;
               case (op_ff)
                  OP_INSERT_AT, OP_SORTED_INSERT: begin
                     // every entry from pos up has moved; drop the key in the gap
                     wr_en   = 1'b1;
                     wr_addr = pos_ff;
                     wr_data = key_ff;
                     ok_in   = 1'b1;
                     fidx_in = pos_ff;
                     cnt_in  = cnt_ff + CW'(1);
                  end
                  OP_DELETE: begin
                     if (found_ff) begin
                        ok_in  = 1'b1;
                        cnt_in = cnt_ff - CW'(1);
                     end
                  end
                  OP_COUNT: begin
                     ok_in = 1'b1;
                  end
                  default: begin
                     ok_in = 1'b0;
                  end
               endcase
            end
         end

         S_BIN_RD: begin
            if (lo_ff < hx_ff) begin
               rd_en    = 1'b1;
               rd_addr  = mid;
               dv_in    = 1'b1;
               didx_in  = mid;
               state_in = S_BIN_CMP;
            end else begin
               state_in = S_RESP;
            end
         end

         S_BIN_CMP: begin
            if (hit) begin
               ok_in    = 1'b1;
               fidx_in  = didx_ff;
               state_in = S_RESP;
            end else begin
               if (rd_data < key_ff) begin
                  lo_in = CW'(didx_ff) + CW'(1);
               end else begin
                  hx_in = CW'(didx_ff);
               end
               state_in = S_BIN_RD;
            end
         end

         S_RESP: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = ok_ff;
               rsp_index_in = fidx_wide[INDEX_BITS-1:0];
               rsp_mcnt_in  = mcnt_wide[SIZE_BITS-1:0];
               rsp_size_in  = size_wide[SIZE_BITS-1:0];
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      key_ff       <= key_in;
      pos_ff       <= pos_in;
      ptr_ff       <= ptr_in;
      rem_ff       <= rem_in;
      didx_ff      <= didx_in;
      found_ff     <= found_in;
      fidx_ff      <= fidx_in;
      mcnt_ff      <= mcnt_in;
      ok_ff        <= ok_in;
      lo_ff        <= lo_in;
      hx_ff        <= hx_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_index_ff <= rsp_index_in;
      rsp_mcnt_ff  <= rsp_mcnt_in;
      rsp_size_ff  <= rsp_size_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         dv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         dv_ff        <= dv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `BALE_ASSERT(a_no_rw_same_entry, clock, reset, !(wr_en && rd_en && wr_addr == rd_addr), "read and write hit the same entry")
   `BALE_ASSERT(a_size_bound, clock, reset, cnt_ff <= CAP_CNT, "list size above capacity")
   `BALE_ASSERT_IMPL(a_size_step, clock, reset, !$past(reset) && cnt_ff != $past(cnt_ff), cnt_ff == $past(cnt_ff) + CW'(1) || cnt_ff == $past(cnt_ff) - CW'(1) || cnt_ff == '0, "list size jumped")
   `BALE_ASSERT_IMPL(a_write_in_scan, clock, reset, wr_en, state_ff == S_SCAN, "memory write outside a scan")
   `BALE_ASSERT_IMPL(a_rsp_from_resp, clock, reset, $rose(rsp_valid_ff), $past(state_ff == S_RESP), "response item without a finished request")

endmodule
`default_nettype wire
